/* hw/rtl/sector_cache_directory_defines.svh */
// Assertion macros for the sector cache directory.
`ifndef SECTOR_CACHE_DIRECTORY_DEFINES_SVH
`define SECTOR_CACHE_DIRECTORY_DEFINES_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SCD_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SCD_ASSERT_IMPL(label, a, c)
`define SCD_ASSERT_NEXT(label, a, c)
`endif
`endif

/* hw/rtl/scd_pkg.sv */
package scd_pkg;
	localparam int unsigned NumEntries = 16;
	localparam int unsigned SlotW = $clog2(NumEntries);
	localparam int unsigned CountW = $clog2(NumEntries + 1);
	// Packed entry: sector, fill stamp, lock count, dirty.
	localparam int unsigned EntryW = 32 + 32 + 8 + 1;

	localparam logic [2:0] KindRead = 3'd0;
	localparam logic [2:0] KindLock = 3'd1;
	localparam logic [2:0] KindUnlock = 3'd2;
	localparam logic [2:0] KindDirty = 3'd3;
	localparam logic [2:0] KindFlush = 3'd4;
	localparam logic [2:0] KindValidate = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] sector;
		logic [SlotW-1:0] slot;
		logic [31:0] handle_stamp;
		logic write_ok;
		logic read_ok;
	} req_t;

	typedef struct packed {
		logic failed;
		logic hit;
		logic [SlotW-1:0] result_slot;
		logic [31:0] result_stamp;
		logic do_writeback;
		logic [31:0] writeback_sector;
		logic do_fill;
		logic [31:0] fill_sector;
		logic stamp_matches;
		logic [CountW-1:0] cached_count;
		logic [CountW-1:0] locked_count;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] sector;
		logic [31:0] stamp;
		logic [7:0] locks;
		logic dirty;
	} entry_t;
endpackage

/* hw/rtl/sector_cache_directory.sv */
// Sector cache directory: tags, lock counts, dirty marks and fill stamps in one RAM.
// A read scans allocated entries, one RAM read a cycle, until a hit; a flush scans
// every one, clearing dirty marks when write_ok is set. A read then decides and writes the new entry.
// Lock, unlock, dirty and validate pass through StHandle. Results come as one-cycle strobes;
// the receiver cannot stall. busy is high from start until the final beat is driven.
// Reset (arst_n low) empties the table and sets min_unlocked to 1; no RAM clear pass.
module sector_cache_directory
	import scd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input req_t req,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	output logic rsp_valid,
	output rsp_t rsp
);
`include "sector_cache_directory_defines.svh"

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StScan = 3'd1;
	localparam logic [2:0] StDecide = 3'd2;
	localparam logic [2:0] StHandle = 3'd4;
	localparam logic [2:0] StFlushEnd = 3'd5;

	logic [2:0] state_q;
	req_t req_q;
	logic [4:0] min_unl_q;
	logic [31:0] stamp_ctr_q;
	logic [CountW-1:0] alloc_q;
	logic [CountW-1:0] locked_q;
	logic [CountW-1:0] idx_q;       // scan read address
	logic rd_pend_q;
	logic [SlotW-1:0] rd_idx_q;
	logic hit_q, found_q;
	logic [SlotW-1:0] hit_slot_q, victim_q;
	entry_t victim_e_q, hit_e_q;
	logic [CountW-1:0] unl_q;
	logic any_wb_q;
	rsp_t flush_q;

	logic we;
	logic [SlotW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	scd_ram #(.Width(EntryW), .Depth(NumEntries)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	rsp_t idle_rsp;
	always_comb begin
		idle_rsp = '0;
		idle_rsp.result_stamp = '1;
		idle_rsp.cached_count = alloc_q;
		idle_rsp.locked_count = locked_q;
	end

	logic slot_ok;
	assign slot_ok = {1'b0, req_q.slot} < alloc_q;
	logic scan_more;
	assign scan_more = idx_q < alloc_q;

	assign busy = state_q != StIdle;
	assign raddr = (state_q == StIdle) ? req.slot : idx_q[SlotW-1:0];

	// A miss takes a new slot (grow) or evicts a victim whose dirty writeback may fail (wb_fail).
	logic grow;
	assign grow = ({1'b0, unl_q} < {1'b0, min_unl_q}) && ({1'b0, alloc_q} < NumEntries[CountW:0]);
	logic wb_fail;
	assign wb_fail = !grow && victim_e_q.dirty && !req_q.write_ok;

	always_comb begin
		we = 1'b0;
		waddr = rd_idx_q;
		wdata = rdata;
		unique case (state_q)
			StScan: if (rd_pend_q && req_q.kind == KindFlush && rdata.dirty && req_q.write_ok) begin
				we = 1'b1;
				wdata.dirty = 1'b0;
			end
			StDecide: if (!hit_q && (grow || found_q)) begin
				waddr = grow ? alloc_q[SlotW-1:0] : victim_q;
				if (wb_fail) begin
					we = 1'b0;
				end else begin
					we = 1'b1;
					wdata.sector = req_q.sector;
					wdata.stamp = stamp_ctr_q + 32'd1;
					wdata.locks = 8'd0;
					wdata.dirty = 1'b0;
				end
			end
			StHandle: if (slot_ok) begin
				waddr = req_q.slot;
				we = (req_q.kind == KindLock && rdata.locks != 8'hff) ||
					(req_q.kind == KindUnlock && rdata.locks != 8'h00) ||
					(req_q.kind == KindDirty);
				if (req_q.kind == KindLock) wdata.locks = rdata.locks + 8'd1;
				if (req_q.kind == KindUnlock) wdata.locks = rdata.locks - 8'd1;
				if (req_q.kind == KindDirty) wdata.dirty = 1'b1;
			end
			default: ;
		endcase
	end

	logic [CountW-1:0] locked_nxt;
	rsp_t wb_beat;
	rsp_t rsp_d;
	logic rsp_vld_d;

	// A flush beat is held until the next dirty entry or the end so that the final one can carry last.
	always_comb begin
		locked_nxt = locked_q;
		if (slot_ok && req_q.kind == KindLock && rdata.locks == 8'd0)
			locked_nxt = locked_q + 1'b1;
		else if (slot_ok && req_q.kind == KindUnlock && rdata.locks == 8'd1)
			locked_nxt = locked_q - 1'b1;

		wb_beat = idle_rsp;
		wb_beat.failed = !req_q.write_ok;
		wb_beat.result_slot = rd_idx_q;
		wb_beat.result_stamp = rdata.stamp;
		wb_beat.do_writeback = 1'b1;
		wb_beat.writeback_sector = rdata.sector;

		rsp_d = idle_rsp;
		rsp_d.last = 1'b1;
		rsp_vld_d = 1'b0;
		unique case (state_q)
			StIdle: if (start && req.kind > KindValidate) rsp_vld_d = 1'b1;
			StHandle: begin
				rsp_vld_d = 1'b1;
				rsp_d.result_slot = req_q.slot;
				if (slot_ok) begin
					rsp_d.result_stamp = rdata.stamp;
					rsp_d.stamp_matches = (req_q.kind == KindValidate) &&
						(rdata.stamp == req_q.handle_stamp);
					rsp_d.locked_count = locked_nxt;
				end
			end
			StScan: if (rd_pend_q && !hit_q && req_q.kind == KindFlush && rdata.dirty &&
				any_wb_q) begin
				rsp_vld_d = 1'b1;
				rsp_d = flush_q;
			end
			StFlushEnd: begin
				rsp_vld_d = 1'b1;
				if (any_wb_q) begin
					rsp_d = flush_q;
					rsp_d.last = 1'b1;
				end
			end
			StDecide: begin
				rsp_vld_d = 1'b1;
				if (hit_q) begin
					rsp_d.hit = 1'b1;
					rsp_d.result_slot = hit_slot_q;
					rsp_d.result_stamp = hit_e_q.stamp;
				end else if (grow || found_q) begin
					rsp_d.result_slot = grow ? alloc_q[SlotW-1:0] : victim_q;
					if (!grow && victim_e_q.dirty) begin
						rsp_d.do_writeback = 1'b1;
						rsp_d.writeback_sector = victim_e_q.sector;
					end
					if (wb_fail) begin
						rsp_d.failed = 1'b1;
					end else begin
						rsp_d.do_fill = 1'b1;
						rsp_d.fill_sector = req_q.sector;
						if (req_q.read_ok) rsp_d.result_stamp = stamp_ctr_q + 32'd1;
						else rsp_d.failed = 1'b1;
						if (grow) rsp_d.cached_count = alloc_q + 1'b1;
					end
				end else begin
					rsp_d.failed = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			min_unl_q <= 5'd1;
			stamp_ctr_q <= '0;
			alloc_q <= '0;
			locked_q <= '0;
			rsp_valid <= 1'b0;
			rsp <= '0;
			rd_pend_q <= 1'b0;
			idx_q <= '0;
			hit_q <= 1'b0;
			found_q <= 1'b0;
			any_wb_q <= 1'b0;
			unl_q <= '0;
		end else begin
			rsp_valid <= rsp_vld_d;
			rsp <= rsp_d;
			if (cfg_we) min_unl_q <= cfg_wdata;
			unique case (state_q)
				StIdle: if (start) begin
					req_q <= req;
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					hit_q <= 1'b0;
					found_q <= 1'b0;
					any_wb_q <= 1'b0;
					unl_q <= '0;
					if (req.kind == KindRead || req.kind == KindFlush) state_q <= StScan;
					else if (req.kind >= KindLock && req.kind <= KindValidate) state_q <= StHandle;
				end
				StHandle: begin
					locked_q <= locked_nxt;
					state_q <= StIdle;
				end
				StScan: begin
					rd_pend_q <= scan_more && !(hit_q);
					rd_idx_q <= idx_q[SlotW-1:0];
					if (scan_more) idx_q <= idx_q + 1'b1;
					if (rd_pend_q && !hit_q) begin
						if (req_q.kind == KindFlush) begin
							if (rdata.dirty) begin
								any_wb_q <= 1'b1;
								flush_q <= wb_beat;
							end
						end else if (rdata.sector == req_q.sector) begin
							hit_q <= 1'b1;
							hit_slot_q <= rd_idx_q;
							hit_e_q <= rdata;
						end else if (rdata.locks == 8'd0) begin
							unl_q <= unl_q + 1'b1;
							if (!found_q || rdata.stamp < victim_e_q.stamp) begin
								found_q <= 1'b1;
								victim_q <= rd_idx_q;
								victim_e_q <= rdata;
							end
						end
					end
					if ((!scan_more && !rd_pend_q) || hit_q ||
						(rd_pend_q && req_q.kind == KindRead && rdata.sector == req_q.sector))
						state_q <= (req_q.kind == KindFlush) ? StFlushEnd : StDecide;
				end
				StFlushEnd: state_q <= StIdle;
				StDecide: begin
					state_q <= StIdle;
					if (!hit_q && (grow || found_q) && !wb_fail) begin
						stamp_ctr_q <= stamp_ctr_q + 32'd1;
						if (grow) alloc_q <= alloc_q + 1'b1;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`SCD_ASSERT_IMPL(a_alloc_bound, 1'b1, alloc_q <= NumEntries[CountW-1:0])
	`SCD_ASSERT_IMPL(a_locked_bound, 1'b1, locked_q <= alloc_q)
	`SCD_ASSERT_NEXT(a_start_busy, start && !busy, busy || rsp_valid)
	`SCD_ASSERT_IMPL(a_no_write_idle, state_q == StIdle, !we)
endmodule

/* hw/rtl/scd_ram.sv */
module scd_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
